@@ rtl/mpe_pkg.sv @@
// Package for the MessagePack value encoder: word types, opcodes and format codes.
`timescale 1ns / 1ps
`default_nettype none

package mpe_pkg;

    // token request opcodes
    localparam logic [3:0] OP_NIL      = 4'd0;
    localparam logic [3:0] OP_BOOL     = 4'd1;
    localparam logic [3:0] OP_SIGNED   = 4'd2;
    localparam logic [3:0] OP_UNSIGNED = 4'd3;
    localparam logic [3:0] OP_FLOAT32  = 4'd4;
    localparam logic [3:0] OP_FLOAT64  = 4'd5;
    localparam logic [3:0] OP_STR      = 4'd6;
    localparam logic [3:0] OP_BIN      = 4'd7;
    localparam logic [3:0] OP_ARRAY    = 4'd8;
    localparam logic [3:0] OP_MAP      = 4'd9;
    localparam logic [3:0] OP_PAYLOAD  = 4'd10;

    // MessagePack lead bytes
    localparam logic [7:0] MP_NIL      = 8'hC0;
    localparam logic [7:0] MP_FALSE    = 8'hC2;
    localparam logic [7:0] MP_TRUE     = 8'hC3;
    localparam logic [7:0] MP_BIN8     = 8'hC4;
    localparam logic [7:0] MP_BIN16    = 8'hC5;
    localparam logic [7:0] MP_BIN32    = 8'hC6;
    localparam logic [7:0] MP_FLOAT32  = 8'hCA;
    localparam logic [7:0] MP_FLOAT64  = 8'hCB;
    localparam logic [7:0] MP_UINT8    = 8'hCC;
    localparam logic [7:0] MP_UINT16   = 8'hCD;
    localparam logic [7:0] MP_UINT32   = 8'hCE;
    localparam logic [7:0] MP_UINT64   = 8'hCF;
    localparam logic [7:0] MP_INT8     = 8'hD0;
    localparam logic [7:0] MP_INT16    = 8'hD1;
    localparam logic [7:0] MP_INT32    = 8'hD2;
    localparam logic [7:0] MP_INT64    = 8'hD3;
    localparam logic [7:0] MP_STR8     = 8'hD9;
    localparam logic [7:0] MP_STR16    = 8'hDA;
    localparam logic [7:0] MP_STR32    = 8'hDB;
    localparam logic [7:0] MP_ARRAY16  = 8'hDC;
    localparam logic [7:0] MP_ARRAY32  = 8'hDD;
    localparam logic [7:0] MP_MAP16    = 8'hDE;
    localparam logic [7:0] MP_MAP32    = 8'hDF;
    localparam logic [7:0] MP_FIXSTR   = 8'hA0;
    localparam logic [7:0] MP_FIXARRAY = 8'h90;
    localparam logic [7:0] MP_FIXMAP   = 8'h80;

    // operand byte counts after the lead byte
    localparam logic [3:0] NB_0 = 4'd0;
    localparam logic [3:0] NB_1 = 4'd1;
    localparam logic [3:0] NB_2 = 4'd2;
    localparam logic [3:0] NB_4 = 4'd4;
    localparam logic [3:0] NB_8 = 4'd8;

    localparam int FRAME_BYTES = 9;

    typedef struct packed {
        logic [3:0]  opcode;
        logic [63:0] value;
        logic [31:0] length;
    } token_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last;
        logic       error;
    } result_t;

    // encoded token: bytes left aligned, first byte in the top lane
    typedef struct packed {
        logic [FRAME_BYTES*8-1:0] bytes;
        logic [3:0]               count;
        logic                     error;
    } frame_t;

endpackage

`default_nettype wire

@@ rtl/msgpack_value_encoder_unit.sv @@
// Top level of the MessagePack value encoder.
// Input channel s_*: one token request word per handshake (opcode, value, length).
// Output channel m_*: one encoded byte word per handshake, big-endian, with last
// on the final byte of a token and error on the single word produced for a str
// or bin length that cannot be encoded. Undefined opcodes are consumed silently.
// A token is encoded in the cycle it is accepted and lands in a frame register;
// its first byte reaches m_* from the output register once that register can load.
// Throughput: one output word per cycle while m_ready is high. A token of N bytes
// (1 to 9) holds the frame register until its last byte moves out, so single-byte
// tokens such as payload bytes stream at one per cycle while m_ready is high.
// s_ready is high when the frame register is empty or its last byte is moving
// into the output register in the same cycle.
// When m_ready is low the output register holds its word and the frame stalls
// behind it; s_ready drops once the frame register is occupied.
// Reset (aresetn low, synchronous) empties both registers; no output words are
// pending afterwards.
`timescale 1ns / 1ps
`default_nettype none

module msgpack_value_encoder_unit (
    input  wire                    aclk,
    input  wire                    aresetn,
    input  wire                    s_valid,
    output logic                   s_ready,
    input  wire mpe_pkg::token_t   s_data,
    output logic                   m_valid,
    input  wire                    m_ready,
    output mpe_pkg::result_t       m_data
);

    mpe_pkg::frame_t enc_frame;

    mpe_encoder u_encoder (
        .token (s_data),
        .frame (enc_frame)
    );

    mpe_serializer u_serializer (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_valid),
        .in_ready (s_ready),
        .in_frame (enc_frame),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

endmodule

`default_nettype wire

@@ rtl/mpe_encoder.sv @@
// Combinational encoder: one token request to a left-aligned frame of up to nine bytes.
`timescale 1ns / 1ps
`default_nettype none

module mpe_encoder (
    input  wire mpe_pkg::token_t token,
    output mpe_pkg::frame_t      frame
);

    logic [7:0]  lead;
    logic [3:0]  nbytes;
    logic        single;
    logic        valid_op;
    logic        err;
    logic [63:0] v;
    logic [31:0] len;
    logic [63:0] operand;
    logic [71:0] packed_bytes;

    assign v   = token.value;
    assign len = token.length;

    always_comb begin
        lead     = 8'h00;
        nbytes   = mpe_pkg::NB_0;
        single   = 1'b0;
        valid_op = 1'b1;
        err      = 1'b0;
        operand  = v;
        case (token.opcode)
            mpe_pkg::OP_NIL: begin
                lead = mpe_pkg::MP_NIL;
            end
            mpe_pkg::OP_BOOL: begin
                lead = v[0] ? mpe_pkg::MP_TRUE : mpe_pkg::MP_FALSE;
            end
            mpe_pkg::OP_SIGNED: begin
                if (v[63:7] == '0 || v[63:5] == '1) begin
                    lead = v[7:0];
                end else if (v[63:7] == '1) begin
                    lead = mpe_pkg::MP_INT8;  nbytes = mpe_pkg::NB_1;
                end else if (v[63:15] == '0 || v[63:15] == '1) begin
                    lead = mpe_pkg::MP_INT16; nbytes = mpe_pkg::NB_2;
                end else if (v[63:31] == '0 || v[63:31] == '1) begin
                    lead = mpe_pkg::MP_INT32; nbytes = mpe_pkg::NB_4;
                end else begin
                    lead = mpe_pkg::MP_INT64; nbytes = mpe_pkg::NB_8;
                end
            end
            mpe_pkg::OP_UNSIGNED: begin
                if (v[63:7] == '0) begin
                    lead = v[7:0];
                end else if (v[63:8] == '0) begin
                    lead = mpe_pkg::MP_UINT8;  nbytes = mpe_pkg::NB_1;
                end else if (v[63:16] == '0) begin
                    lead = mpe_pkg::MP_UINT16; nbytes = mpe_pkg::NB_2;
                end else if (v[63:32] == '0) begin
                    lead = mpe_pkg::MP_UINT32; nbytes = mpe_pkg::NB_4;
                end else begin
                    lead = mpe_pkg::MP_UINT64; nbytes = mpe_pkg::NB_8;
                end
            end
            mpe_pkg::OP_FLOAT32: begin
                lead = mpe_pkg::MP_FLOAT32; nbytes = mpe_pkg::NB_4;
            end
            mpe_pkg::OP_FLOAT64: begin
                lead = mpe_pkg::MP_FLOAT64; nbytes = mpe_pkg::NB_8;
            end
            mpe_pkg::OP_STR, mpe_pkg::OP_BIN: begin
                operand = {32'h0, len};
                if (token.opcode == mpe_pkg::OP_STR && len[31:5] == '0) begin
                    lead = mpe_pkg::MP_FIXSTR | {3'b000, len[4:0]};
                end else if (len[31:8] == '0 && len[7:0] != 8'hFF) begin
                    lead   = (token.opcode == mpe_pkg::OP_STR) ? mpe_pkg::MP_STR8
                                                               : mpe_pkg::MP_BIN8;
                    nbytes = mpe_pkg::NB_1;
                end else if (len[31:16] == '0 && len[15:0] != 16'hFFFF) begin
                    lead   = (token.opcode == mpe_pkg::OP_STR) ? mpe_pkg::MP_STR16
                                                               : mpe_pkg::MP_BIN16;
                    nbytes = mpe_pkg::NB_2;
                end else if (len != 32'hFFFF_FFFF) begin
                    lead   = (token.opcode == mpe_pkg::OP_STR) ? mpe_pkg::MP_STR32
                                                               : mpe_pkg::MP_BIN32;
                    nbytes = mpe_pkg::NB_4;
                end else begin
                    // length cannot be encoded: single zero byte flagged as error
                    lead = 8'h00;
                    err  = 1'b1;
                end
            end
            mpe_pkg::OP_ARRAY, mpe_pkg::OP_MAP: begin
                operand = {32'h0, len};
                if (len[31:4] == '0) begin
                    lead = ((token.opcode == mpe_pkg::OP_ARRAY) ? mpe_pkg::MP_FIXARRAY
                                                                : mpe_pkg::MP_FIXMAP)
                           | {4'h0, len[3:0]};
                end else if (len[31:16] == '0) begin
                    lead   = (token.opcode == mpe_pkg::OP_ARRAY) ? mpe_pkg::MP_ARRAY16
                                                                 : mpe_pkg::MP_MAP16;
                    nbytes = mpe_pkg::NB_2;
                end else begin
                    lead   = (token.opcode == mpe_pkg::OP_ARRAY) ? mpe_pkg::MP_ARRAY32
                                                                 : mpe_pkg::MP_MAP32;
                    nbytes = mpe_pkg::NB_4;
                end
            end
            mpe_pkg::OP_PAYLOAD: begin
                lead = v[7:0];
            end
            default: begin
                valid_op = 1'b0;
                single   = 1'b1;
            end
        endcase
    end

    // left-align operand bytes behind the lead byte, most significant first
    always_comb begin
        case (nbytes)
            mpe_pkg::NB_1: packed_bytes = {lead, operand[7:0],  56'h0};
            mpe_pkg::NB_2: packed_bytes = {lead, operand[15:0], 48'h0};
            mpe_pkg::NB_4: packed_bytes = {lead, operand[31:0], 32'h0};
            mpe_pkg::NB_8: packed_bytes = {lead, operand[63:0]};
            default:       packed_bytes = {lead, 64'h0};
        endcase
    end

    assign frame.bytes = packed_bytes;
    assign frame.count = (valid_op && !single) ? nbytes + 4'd1 : 4'd0;
    assign frame.error = err;

endmodule

`default_nettype wire

@@ rtl/mpe_serializer.sv @@
// Frame register and output register: shifts an encoded frame out one word per cycle while the output is not stalled.
`timescale 1ns / 1ps
`default_nettype none

module mpe_serializer (
    input  wire                   aclk,
    input  wire                   aresetn,
    input  wire                   in_valid,
    output logic                  in_ready,
    input  wire mpe_pkg::frame_t  in_frame,
    output logic                  m_valid,
    input  wire                   m_ready,
    output mpe_pkg::result_t      m_data
);

    logic [71:0]      bytes_reg,  bytes_next;
    logic [3:0]       cnt_reg,    cnt_next;
    logic             err_reg,    err_next;
    logic             fvalid_reg, fvalid_next;
    logic             mvalid_reg, mvalid_next;
    mpe_pkg::result_t mdata_reg,  mdata_next;
    logic             out_load;
    logic             frame_done;

    assign out_load   = !mvalid_reg || m_ready;
    assign frame_done = fvalid_reg && out_load && (cnt_reg == 4'd1);
    assign in_ready   = !fvalid_reg || frame_done;

    always_comb begin
        bytes_next  = bytes_reg;
        cnt_next    = cnt_reg;
        err_next    = err_reg;
        fvalid_next = fvalid_reg;
        mvalid_next = mvalid_reg;
        mdata_next  = mdata_reg;
        if (out_load) begin
            mvalid_next         = fvalid_reg;
            mdata_next.out_byte = bytes_reg[71:64];
            mdata_next.last     = (cnt_reg == 4'd1);
            mdata_next.error    = err_reg;
            if (fvalid_reg) begin
                bytes_next  = {bytes_reg[63:0], 8'h00};
                cnt_next    = cnt_reg - 4'd1;
                fvalid_next = (cnt_reg != 4'd1);
            end
        end
        // undefined opcodes carry a zero count and are dropped here
        if (in_valid && in_ready && in_frame.count != 4'd0) begin
            bytes_next  = in_frame.bytes;
            cnt_next    = in_frame.count;
            err_next    = in_frame.error;
            fvalid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fvalid_reg <= 1'b0;
            mvalid_reg <= 1'b0;
        end else begin
            fvalid_reg <= fvalid_next;
            mvalid_reg <= mvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        bytes_reg <= bytes_next;
        cnt_reg   <= cnt_next;
        err_reg   <= err_next;
        mdata_reg <= mdata_next;
    end

    assign m_valid = mvalid_reg;
    assign m_data  = mdata_reg;

endmodule

`default_nettype wire

@@ tb/tb_top.sv @@
// Testbench for the MessagePack value encoder: byte-stream scoreboard, token stimulus, checks.
`timescale 1ns / 1ps

module tb_top;
    import mpe_pkg::*;

    // opcodes outside the defined set; the block swallows them
    localparam logic [3:0] OP_UNDEF_LO = 4'd11;
    localparam logic [3:0] OP_UNDEF_HI = 4'd15;

    localparam int RANDOM_TOKENS  = 405;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_AT_TOKEN  = 300;
    localparam int HOLD_CYCLES    = 200;
    localparam int STEADY_FROM    = 120;
    localparam int STEADY_TO      = 220;
    localparam int RX_STEADY_FROM = 500;
    localparam int RX_STEADY_TO   = 800;
    localparam int TAIL_CYCLES    = 16;

    // expected byte stream, filled per accepted token, drained per output word
    class encoding_scoreboard;
        result_t expected_bytes[$];
        int      failures = 0;

        function void push_bytes(logic [7:0] lead, logic [63:0] operand, int nb);
            result_t w;
            w.out_byte = lead;
            w.last     = (nb == 0);
            w.error    = 1'b0;
            expected_bytes.push_back(w);
            for (int i = nb - 1; i >= 0; i--) begin
                w.out_byte = operand[8*i +: 8];
                w.last     = (i == 0);
                expected_bytes.push_back(w);
            end
        endfunction

        // str/bin: 8-bit form stops below 255, 16-bit below 65535, all ones is unencodable
        function void sized_header(logic [31:0] n, logic [7:0] c8, logic [7:0] c16,
                                   logic [7:0] c32);
            result_t w;
            if (n < 32'hFF) begin
                push_bytes(c8, {32'd0, n}, 1);
            end else if (n < 32'hFFFF) begin
                push_bytes(c16, {32'd0, n}, 2);
            end else if (n < 32'hFFFF_FFFF) begin
                push_bytes(c32, {32'd0, n}, 4);
            end else begin
                w.out_byte = 8'h00;
                w.last     = 1'b1;
                w.error    = 1'b1;
                expected_bytes.push_back(w);
            end
        endfunction

        function void count_header(logic [31:0] n, logic [7:0] fix, logic [7:0] c16,
                                   logic [7:0] c32);
            if (n <= 32'd15)
                push_bytes(fix | n[7:0], 64'd0, 0);
            else if (n <= 32'hFFFF)
                push_bytes(c16, {32'd0, n}, 2);
            else
                push_bytes(c32, {32'd0, n}, 4);
        endfunction

        function void note_token(token_t t);
            logic [63:0] v;
            logic [31:0] n;
            v = t.value;
            n = t.length;
            case (t.opcode)
                OP_NIL:  push_bytes(MP_NIL, 64'd0, 0);
                OP_BOOL: push_bytes(v[0] ? MP_TRUE : MP_FALSE, 64'd0, 0);
                OP_SIGNED: begin
                    // v + half < 2*half: two's complement range check (fixint: -32 to 127)
                    if (v + 64'd32 < 64'd160)
                        push_bytes(v[7:0], 64'd0, 0);
                    else if (v + 64'd128 < 64'd256)
                        push_bytes(MP_INT8, v, 1);
                    else if (v + 64'h8000 < 64'h1_0000)
                        push_bytes(MP_INT16, v, 2);
                    else if (v + 64'h8000_0000 < 64'h1_0000_0000)
                        push_bytes(MP_INT32, v, 4);
                    else
                        push_bytes(MP_INT64, v, 8);
                end
                OP_UNSIGNED: begin
                    if (v <= 64'd127)
                        push_bytes(v[7:0], 64'd0, 0);
                    else if (v <= 64'hFF)
                        push_bytes(MP_UINT8, v, 1);
                    else if (v <= 64'hFFFF)
                        push_bytes(MP_UINT16, v, 2);
                    else if (v <= 64'hFFFF_FFFF)
                        push_bytes(MP_UINT32, v, 4);
                    else
                        push_bytes(MP_UINT64, v, 8);
                end
                OP_FLOAT32: push_bytes(MP_FLOAT32, v, 4);
                OP_FLOAT64: push_bytes(MP_FLOAT64, v, 8);
                OP_STR: begin
                    if (n <= 32'd31)
                        push_bytes(MP_FIXSTR | n[7:0], 64'd0, 0);
                    else
                        sized_header(n, MP_STR8, MP_STR16, MP_STR32);
                end
                OP_BIN:     sized_header(n, MP_BIN8, MP_BIN16, MP_BIN32);
                OP_ARRAY:   count_header(n, MP_FIXARRAY, MP_ARRAY16, MP_ARRAY32);
                OP_MAP:     count_header(n, MP_FIXMAP, MP_MAP16, MP_MAP32);
                OP_PAYLOAD: push_bytes(v[7:0], 64'd0, 0);
                default: ;
            endcase
        endfunction

        function void check_word(result_t got);
            result_t want;
            if (expected_bytes.size() == 0) begin
                failures++;
                if (failures <= 10)
                    $display("unexpected word: byte=%02h last=%0d error=%0d",
                             got.out_byte, got.last, got.error);
                return;
            end
            want = expected_bytes.pop_front();
            if (got.out_byte !== want.out_byte || got.last !== want.last ||
                got.error !== want.error) begin
                failures++;
                if (failures <= 10)
                    $display("mismatch: exp %02h last=%0d err=%0d, got %02h last=%0d err=%0d",
                             want.out_byte, want.last, want.error,
                             got.out_byte, got.last, got.error);
            end
        endfunction

        function int pending();
            return expected_bytes.size();
        endfunction

        function void close();
            if (expected_bytes.size() != 0) begin
                failures++;
                if (failures <= 10)
                    $display("%0d expected words never arrived", expected_bytes.size());
            end
        endfunction
    endclass

    logic    aclk    = 1'b0;
    logic    aresetn = 1'b0;
    logic    s_valid = 1'b0;
    logic    s_ready;
    token_t  s_data  = '0;
    logic    m_valid;
    logic    m_ready = 1'b0;
    result_t m_data;

    encoding_scoreboard enc_sb = new();

    int tokens_seen  = 0;
    int words_seen   = 0;
    int quiet_cycles = 0;
    int hold_left    = 0;
    bit hold_done    = 1'b0;
    bit tx_steady    = 1'b0;

    msgpack_value_encoder_unit u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // handshake monitor and watchdog; output checked before the new token is noted
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                enc_sb.check_word(m_data);
                words_seen <= words_seen + 1;
            end
            if (s_valid && s_ready) begin
                enc_sb.note_token(s_data);
                tokens_seen <= tokens_seen + 1;
            end
            if ((m_valid && m_ready) || (s_valid && s_ready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("Some tests failed");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // receiver: random backpressure, one long hold, one stretch always ready
    always @(posedge aclk) begin
        if (hold_left != 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (!hold_done && tokens_seen >= HOLD_AT_TOKEN) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            m_ready   <= 1'b0;
        end else if (words_seen >= RX_STEADY_FROM && words_seen < RX_STEADY_TO) begin
            m_ready <= 1'b1;
        end else begin
            m_ready <= ($urandom_range(99) >= 6);
        end
    end

    function automatic token_t make_token(logic [3:0] op, logic [63:0] v, logic [31:0] n);
        token_t t;
        t.opcode = op;
        t.value  = v;
        t.length = n;
        return t;
    endfunction

    // values clustered around powers of two so every integer form boundary is hit
    function automatic logic [63:0] pick_value();
        logic [63:0] base;
        logic [63:0] v;
        int unsigned k;
        k    = $urandom_range(1, 64);
        base = (k == 64) ? 64'd0 : (64'd1 << k);
        case ($urandom_range(2))
            0:       v = {$urandom, $urandom};
            1:       v = base + 64'($urandom_range(3)) - 64'd2;
            default: v = {$urandom, $urandom} & (base - 64'd1);
        endcase
        if ($urandom_range(1) == 1)
            v = -v;
        return v;
    endfunction

    function automatic logic [31:0] pick_count();
        logic [32:0] base;
        logic [31:0] n;
        int unsigned k;
        k    = $urandom_range(0, 32);
        base = 33'd1 << k;
        case ($urandom_range(2))
            0:       n = $urandom;
            1:       n = base[31:0] + 32'($urandom_range(3)) - 32'd2;
            default: n = $urandom & (base[31:0] - 32'd1);
        endcase
        return n;
    endfunction

    function automatic token_t random_token();
        logic [3:0]  op;
        int unsigned r;
        r = $urandom_range(99);
        if (r < 30)
            op = OP_PAYLOAD;
        else if (r < 33)
            op = 4'($urandom_range(OP_UNDEF_LO, OP_UNDEF_HI));
        else
            op = 4'($urandom_range(OP_NIL, OP_MAP));
        return make_token(op, pick_value(), pick_count());
    endfunction

    task automatic send_token(input token_t t);
        if (!tx_steady) begin
            while ($urandom_range(99) < 6) begin
                s_valid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_valid <= 1'b1;
        s_data  <= t;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (enc_sb.pending() != 0)
            @(posedge aclk);
    endtask

    initial begin
        token_t t;
        int     defined_sent;
        bit     mid_drain_done;
        defined_sent   = 0;
        mid_drain_done = 1'b0;

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: form boundaries, ignored operand bits, unencodable lengths
        send_token(make_token(OP_NIL, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF));
        send_token(make_token(OP_BOOL, 64'hFFFF_FFFF_FFFF_FFFE, 32'd0));
        send_token(make_token(OP_BOOL, 64'd1, 32'd0));
        send_token(make_token(OP_SIGNED, 64'hFFFF_FFFF_FFFF_FFE0, 32'd0));
        send_token(make_token(OP_SIGNED, 64'hFFFF_FFFF_FFFF_FFDF, 32'd0));
        send_token(make_token(OP_SIGNED, 64'd127, 32'd0));
        send_token(make_token(OP_SIGNED, 64'd128, 32'd0));
        send_token(make_token(OP_SIGNED, 64'hFFFF_FFFF_8000_0000, 32'd0));
        send_token(make_token(OP_SIGNED, 64'h8000_0000_0000_0000, 32'd0));
        send_token(make_token(OP_UNSIGNED, 64'd128, 32'd0));
        send_token(make_token(OP_UNSIGNED, 64'hFFFF_FFFF_FFFF_FFFF, 32'd0));
        send_token(make_token(OP_FLOAT32, 64'hDEAD_BEEF_3F80_0000, 32'd0));
        send_token(make_token(OP_FLOAT64, 64'hC009_21FB_5444_2D18, 32'd0));
        send_token(make_token(OP_STR, 64'd0, 32'd31));
        send_token(make_token(OP_STR, 64'd0, 32'd255));
        send_token(make_token(OP_STR, 64'd0, 32'hFFFF_FFFF));
        send_token(make_token(OP_BIN, 64'd0, 32'd0));
        send_token(make_token(OP_BIN, 64'd0, 32'hFFFF_FFFE));
        send_token(make_token(OP_BIN, 64'd0, 32'hFFFF_FFFF));
        send_token(make_token(OP_ARRAY, 64'd0, 32'd15));
        send_token(make_token(OP_ARRAY, 64'd0, 32'h1_0000));
        send_token(make_token(OP_MAP, 64'd0, 32'hFFFF));
        send_token(make_token(OP_PAYLOAD, 64'hFFFF_FFFF_FFFF_FF5A, 32'hFFFF_FFFF));
        send_token(make_token(OP_UNDEF_LO, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF));
        send_token(make_token(OP_UNDEF_HI, 64'd0, 32'd0));
        wait_drained();

        while (defined_sent < RANDOM_TOKENS) begin
            if (defined_sent == 60 && !mid_drain_done) begin
                mid_drain_done = 1'b1;
                wait_drained();
            end
            tx_steady = (defined_sent >= STEADY_FROM && defined_sent < STEADY_TO);
            t = random_token();
            send_token(t);
            if (t.opcode <= OP_PAYLOAD)
                defined_sent++;
        end
        tx_steady = 1'b0;

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge aclk);
        enc_sb.close();
        if (enc_sb.failures == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

@@ msgpack_value_encoder_unit.f @@
rtl/mpe_pkg.sv
rtl/mpe_encoder.sv
rtl/mpe_serializer.sv
rtl/msgpack_value_encoder_unit.sv
tb/tb_top.sv
